[src/fppr_pkg.sv]
// shared types and constants for the fifo page frame replacer
// no dependencies; imported by the interfaces, the frame cell and the top level
package fppr_pkg;

    localparam int FRAME_COUNT_DEF = 32;
    localparam int PID_W   = 16;
    localparam int PAGE_W  = 20;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 32;
    localparam int FIDX_W  = 5;
    localparam int FREED_W = 6;
    // frame numbers carried along the chain; covers the largest table of 256
    localparam int TIDX_W  = 8;

    localparam logic REQ_REF    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [FREED_W-1:0] FREED_SAT = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } t_state;

    // search token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
        logic               hit;
        logic [TIDX_W-1:0]  hit_idx;
        logic               have_free;
        logic [TIDX_W-1:0]  free_idx;
        logic               second_free;
        logic [STAMP_W-1:0] min_stamp;
        logic [TIDX_W-1:0]  min_idx;
        logic [FREED_W-1:0] freed;
    } t_token;

    // broadcast write of one frame at the end of a miss
    typedef struct packed {
        logic               en;
        logic [TIDX_W-1:0]  idx;
        logic [PID_W-1:0]   owner;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } t_fill;

    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame_index;
        logic               replaced;
        logic               fault_counted;
        logic [FAULT_W-1:0] fault_total;
        logic [FREED_W-1:0] freed_count;
    } t_result;

endpackage

[src/fppr_if.sv]
// request and response channel interfaces, valid/ready handshake
// depends on fppr_pkg for field widths
interface fppr_req_if import fppr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [PID_W-1:0]  proc_id;
    logic [PAGE_W-1:0] page_num;

    modport source (output valid, req_type, proc_id, page_num, input ready);
    modport sink   (input valid, req_type, proc_id, page_num, output ready);
endinterface

interface fppr_rsp_if import fppr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIDX_W-1:0]  frame_index;
    logic               replaced;
    logic               fault_counted;
    logic [FAULT_W-1:0] fault_total;
    logic [FREED_W-1:0] freed_count;

    modport source (output valid, hit, frame_index, replaced, fault_counted, fault_total,
                    freed_count, input ready);
    modport sink   (input valid, hit, frame_index, replaced, fault_counted, fault_total,
                    freed_count, output ready);
endinterface

[src/fifo_page_frame_replacer.sv]
// fifo page frame replacer: controller and the chain of frame cells
// depends on fppr_pkg, fppr_if (fppr_req_if, fppr_rsp_if) and fppr_cell
//
// Requests arrive on i_req: req_type 0 references (proc_id, page_num), req_type 1
// frees every frame owned by proc_id. Each request yields one response on o_rsp.
// A request is taken only while the controller is idle. It enters the head of a
// row of FRAME_COUNT cells, one frame per cell, and walks one cell per cycle,
// gathering the first match, the first two free frames and the oldest stamp;
// removals clear matching cells as the token passes. After the tail the token is
// latched, and the finish step picks the frame, writes it into its cell and
// loads the response register.
// A new request is taken only once the finish step has loaded the response, so
// the row holds one request at a time.
// Reset clears every frame to free, the stamp counter to one, the fault total
// to zero and fault counting off. The response register parts the two sides:
// a finished result may wait while the next request walks the row; a stalled
// receiver holds only the finish step of the following request.
module fifo_page_frame_replacer import fppr_pkg::*; #(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fppr_req_if.sink   i_req,
    fppr_rsp_if.source o_rsp
);

    t_token w_tok [FRAME_COUNT+1];
    t_fill  w_fill;

    t_state             r_state, n_state;
    t_token             r_tail;
    t_result            r_res, n_res;
    logic               r_out_valid;
    logic [STAMP_W-1:0] r_next_stamp, n_next_stamp;
    logic               r_counting_on, n_counting_on;
    logic [FAULT_W-1:0] r_fault_count, n_fault_count;
    logic               w_ready;
    logic               w_load;
    logic               w_accept;
    logic               w_any_free;

    assign w_accept = i_req.valid && w_ready;

    // head token built straight from the request
    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].valid     = w_accept;
        w_tok[0].req_type  = i_req.req_type;
        w_tok[0].pid       = i_req.proc_id;
        w_tok[0].page      = i_req.page_num;
        w_tok[0].min_stamp = '1;
    end

    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        fppr_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_fill  (w_fill),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_res         = r_res;
        n_next_stamp  = r_next_stamp;
        n_counting_on = r_counting_on;
        n_fault_count = r_fault_count;
        w_fill        = '0;
        w_ready       = 1'b0;
        w_load        = 1'b0;
        w_any_free    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_tok[FRAME_COUNT].valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                    n_res   = '0;
                    n_res.fault_total = r_fault_count;
                    if (r_tail.req_type == REQ_REMOVE) begin
                        n_res.freed_count = r_tail.freed;
                    end else begin
                        if (r_tail.hit) begin
                            n_res.hit         = 1'b1;
                            n_res.frame_index = FIDX_W'(r_tail.hit_idx);
                            w_any_free        = r_tail.have_free;
                        end else begin
                            w_fill.en    = 1'b1;
                            w_fill.idx   = r_tail.have_free ? r_tail.free_idx : r_tail.min_idx;
                            w_fill.owner = r_tail.pid;
                            w_fill.page  = r_tail.page;
                            w_fill.stamp = r_next_stamp;
                            n_next_stamp = r_next_stamp + 1'b1;
                            n_res.frame_index = FIDX_W'(w_fill.idx);
                            n_res.replaced    = !r_tail.have_free;
                            if (r_counting_on) begin
                                n_fault_count       = r_fault_count + 1'b1;
                                n_res.fault_counted = 1'b1;
                                n_res.fault_total   = r_fault_count + 1'b1;
                            end
                            // a wrapped stamp of zero leaves the filled frame looking free
                            w_any_free = (r_tail.have_free && r_tail.second_free)
                                      || (r_next_stamp == '0);
                        end
                        if (!r_counting_on) begin
                            n_counting_on = !w_any_free;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_next_stamp  <= STAMP_W'(1);
            r_counting_on <= 1'b0;
            r_fault_count <= '0;
        end else begin
            r_state       <= n_state;
            r_next_stamp  <= n_next_stamp;
            r_counting_on <= n_counting_on;
            r_fault_count <= n_fault_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[FRAME_COUNT].valid) begin
            r_tail <= w_tok[FRAME_COUNT];
        end
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign i_req.ready         = w_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_res.hit;
    assign o_rsp.frame_index   = r_res.frame_index;
    assign o_rsp.replaced      = r_res.replaced;
    assign o_rsp.fault_counted = r_res.fault_counted;
    assign o_rsp.fault_total   = r_res.fault_total;
    assign o_rsp.freed_count   = r_res.freed_count;

    a_tail_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[FRAME_COUNT].valid |-> r_state == ST_BUSY)
        else $error("token left the chain outside a walk");

    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_BUSY)
        else $error("accepted request did not start a walk");

    a_fill_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill.en |-> r_state == ST_DONE && w_load)
        else $error("frame written outside the finish step");

    a_counting_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counting_on |=> r_counting_on)
        else $error("fault counting switched off");

    a_hit_not_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.hit |-> !r_res.replaced && !r_res.fault_counted)
        else $error("hit response flagged as a miss");

endmodule

[src/fppr_cell.sv]
// one page frame: owner, page and stamp, plus one stage of the search token
// depends on fppr_pkg (t_token, t_fill)
module fppr_cell import fppr_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    input  t_fill  i_fill,
    output t_token o_tok
);

    localparam logic [TIDX_W-1:0] MY_IDX = TIDX_W'(CELL_IDX);

    logic [PID_W-1:0]   r_owner, n_owner;
    logic [PAGE_W-1:0]  r_page,  n_page;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    t_token             r_tok,   n_tok;

    always_comb begin
        n_owner = r_owner;
        n_page  = r_page;
        n_stamp = r_stamp;
        n_tok   = i_tok;

        if (i_fill.en && i_fill.idx == MY_IDX) begin
            n_owner = i_fill.owner;
            n_page  = i_fill.page;
            n_stamp = i_fill.stamp;
        end

        if (i_tok.valid) begin
            if (i_tok.req_type == REQ_REMOVE) begin
                if (r_owner == i_tok.pid) begin
                    n_owner = '0;
                    n_page  = '0;
                    n_stamp = '0;
                    if (i_tok.freed != FREED_SAT) begin
                        n_tok.freed = i_tok.freed + 1'b1;
                    end
                end
            end else begin
                // first match wins
                if (!i_tok.hit && r_owner == i_tok.pid && r_page == i_tok.page) begin
                    n_tok.hit     = 1'b1;
                    n_tok.hit_idx = MY_IDX;
                end
                if (r_stamp == '0) begin
                    if (!i_tok.have_free) begin
                        n_tok.have_free = 1'b1;
                        n_tok.free_idx  = MY_IDX;
                    end else begin
                        n_tok.second_free = 1'b1;
                    end
                end
                // strict compare keeps the lowest index on ties
                if (r_stamp < i_tok.min_stamp) begin
                    n_tok.min_stamp = r_stamp;
                    n_tok.min_idx   = MY_IDX;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_page  <= '0;
            r_stamp <= '0;
            r_tok   <= '0;
        end else begin
            r_owner <= n_owner;
            r_page  <= n_page;
            r_stamp <= n_stamp;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
